### rtl/core/dvtu_pkg.sv
// ----------------------------------------------------------------------------
// dvtu_pkg
// Shared types and constants of the distance-vector table update block.
// ----------------------------------------------------------------------------
package dvtu_pkg;

   localparam int DEFAULT_ENTRIES = 8;

   localparam int OP_W     = 2;
   localparam int INDEX_W  = 3;
   localparam int ROUTER_W = 8;
   localparam int IFACE_W  = 8;
   localparam int COST_W   = 16;
   localparam int ENTRY_W  = ROUTER_W + IFACE_W + COST_W;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_BEGIN  = 2'd1,
      OP_ADVERT = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   // one table slot as held in the table RAM
   typedef struct packed {
      logic [ROUTER_W-1:0] dest;
      logic [IFACE_W-1:0]  iface;
      logic [COST_W-1:0]   cost;
   } entry_type;

   // verdict of the shared compare unit on one slot
   typedef struct packed {
      logic              match;
      logic              lower;
      logic [COST_W-1:0] sum;
   } relax_type;

endpackage

### rtl/core/dvtu_ram.sv
// ----------------------------------------------------------------------------
// dvtu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dvtu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### rtl/core/dvtu_relax.sv
// ----------------------------------------------------------------------------
// dvtu_relax
// Shared compare unit: destination match, cost sum and strict-lower test.
// ----------------------------------------------------------------------------
module dvtu_relax (
   input  dvtu_pkg::entry_type              entry,
   input  logic                             entry_valid,
   input  logic [dvtu_pkg::ROUTER_W-1:0]    router_id,
   input  logic [dvtu_pkg::COST_W-1:0]      adv_cost,
   input  logic [dvtu_pkg::COST_W-1:0]      via_cost,
   output dvtu_pkg::relax_type              verdict
);

   import dvtu_pkg::*;

   logic [COST_W:0] sum;

   // 17-bit sum, so no wrap
   assign sum = {1'b0, adv_cost} + {1'b0, via_cost};

   always_comb begin
      verdict.match = entry_valid && (entry.dest == router_id);
      verdict.lower = verdict.match && (sum < {1'b0, entry.cost});
      verdict.sum   = sum[COST_W-1:0];
   end

endmodule

### rtl/core/distance_vector_table_update.sv
// ----------------------------------------------------------------------------
// distance_vector_table_update
// Routing table with load, read, begin-vector and advertised-entry commands.
// ----------------------------------------------------------------------------
// From accepted start to rsp_strobe: a load writes its slot in ST_LOAD, a read
// passes ST_READ and ST_RDATA, and begin vector and advertised entry scan every slot.
// One command at a time: busy stays high until the result beat is issued, and
// a new start is taken in the very cycle that rsp_strobe is high.
// The scan time is set by the table RAM's single read port, one slot a cycle.
// Synchronous reset marks every slot invalid and clears the latched via pair.
// ----------------------------------------------------------------------------
module distance_vector_table_update #(
   parameter int ENTRIES = dvtu_pkg::DEFAULT_ENTRIES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [dvtu_pkg::OP_W-1:0]       req_operation,
   input  logic [dvtu_pkg::INDEX_W-1:0]    req_entry_index,
   input  logic [dvtu_pkg::ROUTER_W-1:0]   req_router_id,
   input  logic [dvtu_pkg::IFACE_W-1:0]    req_link_interface,
   input  logic [dvtu_pkg::COST_W-1:0]     req_path_cost,
   output logic                            rsp_strobe,
   output logic [dvtu_pkg::INDEX_W-1:0]    rsp_out_index,
   output logic [dvtu_pkg::ROUTER_W-1:0]   rsp_out_router,
   output logic [dvtu_pkg::IFACE_W-1:0]    rsp_out_interface,
   output logic [dvtu_pkg::COST_W-1:0]     rsp_out_cost,
   output logic                            rsp_out_valid,
   output logic                            rsp_hit_flag
);

   import dvtu_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_LOAD  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_RDATA = 5'b01000,
      ST_SCAN  = 5'b10000
   } state_type;

   // sequencer state
   state_type            state_ff,     state_in;
   logic [CNT_W-1:0]     scan_cnt_ff,  scan_cnt_in;
   logic                 chk_vld_ff,   chk_vld_in;
   logic [IDX_W-1:0]     chk_addr_ff,  chk_addr_in;
   logic                 found_ff,     found_in;
   logic                 hit_ff,       hit_in;

   // table valid bits and latched via pair
   logic [ENTRIES-1:0]   valid_ff,     valid_in;
   logic [IFACE_W-1:0]   via_iface_ff, via_iface_in;
   logic [COST_W-1:0]    via_cost_ff,  via_cost_in;

   // command beat held for the duration of the command
   op_type               op_ff,        op_in;
   logic [INDEX_W-1:0]   index_ff,     index_in;
   logic [ROUTER_W-1:0]  router_ff,    router_in;
   logic [IFACE_W-1:0]   iface_ff,     iface_in;
   logic [COST_W-1:0]    cost_ff,      cost_in;

   // result beat
   logic                 strobe_ff,    strobe_in;
   logic [INDEX_W-1:0]   o_index_ff,   o_index_in;
   logic [ROUTER_W-1:0]  o_router_ff,  o_router_in;
   logic [IFACE_W-1:0]   o_iface_ff,   o_iface_in;
   logic [COST_W-1:0]    o_cost_ff,    o_cost_in;
   logic                 o_valid_ff,   o_valid_in;
   logic                 o_hit_ff,     o_hit_in;

   // table RAM port
   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   entry_type            ram_wdata;
   logic [IDX_W-1:0]     ram_raddr;
   logic [ENTRY_W-1:0]   ram_rdata;
   entry_type            rd_entry;

   logic                 accept;
   logic                 in_range;
   logic [IDX_W-1:0]     req_addr;
   relax_type            verdict;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign in_range  = (32'(index_ff) < ENTRIES);
   assign req_addr  = IDX_W'(index_ff);
   assign rd_entry  = entry_type'(ram_rdata);

   dvtu_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // one slot judged per cycle, for both begin vector and advertised entry
   dvtu_relax u_relax (
      .entry       (rd_entry),
      .entry_valid (valid_ff[chk_addr_ff]),
      .router_id   (router_ff),
      .adv_cost    (cost_ff),
      .via_cost    (via_cost_ff),
      .verdict     (verdict)
   );

   always_comb begin
      state_in     = state_ff;
      scan_cnt_in  = scan_cnt_ff;
      chk_vld_in   = 1'b0;
      chk_addr_in  = chk_addr_ff;
      found_in     = found_ff;
      hit_in       = hit_ff;
      valid_in     = valid_ff;
      via_iface_in = via_iface_ff;
      via_cost_in  = via_cost_ff;
      op_in        = op_ff;
      index_in     = index_ff;
      router_in    = router_ff;
      iface_in     = iface_ff;
      cost_in      = cost_ff;
      strobe_in    = 1'b0;
      o_index_in   = index_ff;
      o_router_in  = '0;
      o_iface_in   = '0;
      o_cost_in    = '0;
      o_valid_in   = 1'b0;
      o_hit_in     = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = req_addr;
      ram_wdata    = '{dest: router_ff, iface: iface_ff, cost: cost_ff};
      ram_raddr    = req_addr;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // capture the command beat and pick the sequence
               op_in       = op_type'(req_operation);
               index_in    = req_entry_index;
               router_in   = req_router_id;
               iface_in    = req_link_interface;
               cost_in     = req_path_cost;
               scan_cnt_in = '0;
               found_in    = 1'b0;
               hit_in      = 1'b0;
               unique case (op_type'(req_operation))
                  OP_LOAD:   state_in = ST_LOAD;
                  OP_READ:   state_in = ST_READ;
                  OP_BEGIN: begin
                     // a new vector forgets the previous sender
                     via_iface_in = '0;
                     via_cost_in  = '0;
                     state_in     = ST_SCAN;
                  end
                  OP_ADVERT: state_in = ST_SCAN;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end

         ST_LOAD: begin
            // drop loads aimed beyond the table
            if (in_range) begin
               ram_we             = 1'b1;
               valid_in[req_addr] = 1'b1;
            end
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end

         ST_READ: begin
            state_in = ST_RDATA;
         end

         ST_RDATA: begin
            // an invalid or out-of-range slot reads back as all zero
            if (in_range && valid_ff[req_addr]) begin
               o_router_in = rd_entry.dest;
               o_iface_in  = rd_entry.iface;
               o_cost_in   = rd_entry.cost;
               o_valid_in  = 1'b1;
            end
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end

         ST_SCAN: begin
            // issue the next slot address while the previous one is judged
            if (scan_cnt_ff != CNT_W'(ENTRIES)) begin
               ram_raddr   = scan_cnt_ff[IDX_W-1:0];
               chk_vld_in  = 1'b1;
               chk_addr_in = scan_cnt_ff[IDX_W-1:0];
               scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            end

            if (chk_vld_ff) begin
               if (op_ff == OP_BEGIN) begin
                  // first matching slot wins
                  if (verdict.match && !found_ff) begin
                     via_iface_in = rd_entry.iface;
                     via_cost_in  = rd_entry.cost;
                     found_in     = 1'b1;
                     hit_in       = 1'b1;
                  end
               end else if (verdict.lower) begin
                  // write back the cheaper route through the sender
                  ram_we    = 1'b1;
                  ram_waddr = chk_addr_ff;
                  ram_wdata = '{dest: rd_entry.dest, iface: via_iface_ff, cost: verdict.sum};
                  hit_in    = 1'b1;
               end
            end

            if ((scan_cnt_ff == CNT_W'(ENTRIES)) && !chk_vld_ff) begin
               o_hit_in  = hit_ff;
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_cnt_ff  <= '0;
         chk_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         hit_ff       <= 1'b0;
         valid_ff     <= '0;
         via_iface_ff <= '0;
         via_cost_ff  <= '0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         chk_vld_ff   <= chk_vld_in;
         found_ff     <= found_in;
         hit_ff       <= hit_in;
         valid_ff     <= valid_in;
         via_iface_ff <= via_iface_in;
         via_cost_ff  <= via_cost_in;
         strobe_ff    <= strobe_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      chk_addr_ff <= chk_addr_in;
      op_ff       <= op_in;
      index_ff    <= index_in;
      router_ff   <= router_in;
      iface_ff    <= iface_in;
      cost_ff     <= cost_in;
      o_index_ff  <= o_index_in;
      o_router_ff <= o_router_in;
      o_iface_ff  <= o_iface_in;
      o_cost_ff   <= o_cost_in;
      o_valid_ff  <= o_valid_in;
      o_hit_ff    <= o_hit_in;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_out_index     = o_index_ff;
   assign rsp_out_router    = o_router_ff;
   assign rsp_out_interface = o_iface_ff;
   assign rsp_out_cost      = o_cost_ff;
   assign rsp_out_valid     = o_valid_ff;
   assign rsp_hit_flag      = o_hit_ff;

`ifndef SYNTH
   // a result beat always closes a command that was in flight
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result beat without a command in flight");

   // the table is written only under a command
   a_write_when_busy: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> busy)
      else $error("table write while idle");

   // a slot under judgement never outlives the scan
   a_check_in_scan: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> (state_ff == ST_SCAN))
      else $error("slot check pending outside the scan");

   // a valid read-back only comes with a read command's beat
   a_valid_on_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_out_valid && rsp_strobe |-> ($past(op_ff) == OP_READ))
      else $error("valid read-back outside a read");
`endif

endmodule
